/* rtl/rhh_pkg.sv */
// Package for the Robin Hood hash table unit: request and status codes,
// controller states and the command/status structs between control and datapath.
// No dependencies.
`timescale 1ns / 1ps

package rhh_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [7:0] DIST_EMPTY = 8'd0;
    localparam logic [7:0] DIST_TOMB  = 8'd255;
    localparam logic [7:0] MAX_RESET  = 8'd96;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_PROBE,
        S_EVAL,
        S_COMMIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       load;        // capture request beat
        logic       probe;       // read slot, advance probe count
        logic       tomb_rec;    // remember first tombstone
        logic       swap;        // displace richer entry
        logic       ins_wr_hit;  // place carried entry at empty slot or tombstone
        logic       ins_wr_tomb; // place carried entry at tombstone at bound
        logic       rem_wr;      // mark found slot as tombstone
        logic       dec;         // drop live count
        logic       commit;      // make shadow writes current
        logic       abort;       // drop shadow writes
        logic       set_res;     // hold pending result
        logic [1:0] res_status;
        logic       res_found;   // pending value from slot, else zero
        logic       emit;        // move pending result to output
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       full;
        logic       at_bound;
        logic       have_tomb;
        logic       d_empty;
        logic       d_tomb;
        logic       match;
        logic       richer;
        logic       out_busy;
    } sts_t;

endpackage

/* rtl/rhh_ctrl.sv */
// Controller state machine for the Robin Hood hash table unit.
// Depends on rhh_pkg.
`timescale 1ns / 1ps

module rhh_ctrl
    import rhh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (sts.req)
                    REQ_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = ST_FULL;
                            state_next     = S_DONE;
                        end
                        else
                            state_next = S_PROBE;
                    end
                    REQ_LOOKUP, REQ_REMOVE:
                        state_next = S_PROBE;
                    default:
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_MISS;
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_PROBE:
            begin
                if (sts.at_bound)
                begin
                    if (sts.req == REQ_INSERT && sts.have_tomb)
                    begin
                        cmd.ins_wr_tomb = 1'b1;
                        state_next      = S_COMMIT;
                    end
                    else
                    begin
                        cmd.abort      = 1'b1;
                        cmd.set_res    = 1'b1;
                        cmd.res_status = (sts.req == REQ_INSERT) ? ST_FULL : ST_MISS;
                        state_next     = S_DONE;
                    end
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_PROBE;
                if (sts.req == REQ_INSERT)
                begin
                    if (sts.d_empty)
                    begin
                        cmd.ins_wr_hit = 1'b1;
                        state_next     = S_COMMIT;
                    end
                    else if (sts.d_tomb)
                        cmd.tomb_rec = 1'b1;
                    else if (sts.match)
                    begin
                        cmd.abort      = 1'b1;
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_DUP;
                        state_next     = S_DONE;
                    end
                    else if (sts.richer)
                        cmd.swap = 1'b1;
                end
                else
                begin
                    if (sts.d_empty)
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_MISS;
                        state_next     = S_DONE;
                    end
                    else if (!sts.d_tomb && sts.match)
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_OK;
                        cmd.res_found  = 1'b1;
                        cmd.rem_wr     = (sts.req == REQ_REMOVE);
                        cmd.dec        = (sts.req == REQ_REMOVE);
                        state_next     = S_DONE;
                    end
                end
            end
            S_COMMIT:
            begin
                cmd.commit     = 1'b1;
                cmd.set_res    = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

/* rtl/rhh_datapath.sv */
// Datapath for the Robin Hood hash table unit: two slot banks with per-slot
// bank select and shadow bits, carried entry, probe counter and result registers.
// Depends on rhh_pkg.
`timescale 1ns / 1ps

module rhh_datapath
    import rhh_pkg::*;
#(
    parameter int TABLE_SIZE  = 128,
    parameter int PROBE_BOUND = 64,
    parameter int KEY_WIDTH   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [1:0]  req_type,
    input  logic [31:0] key,
    input  logic [31:0] key_hash,
    input  logic [31:0] value,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] value_out,
    output logic [7:0]  entry_count
);

    // Table size is a power of two; slot index is the low bits of the probe sum.
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam logic [7:0] BOUND = 8'(PROBE_BOUND);

    logic [KW-1:0] mem_key  [2][TABLE_SIZE];
    logic [31:0]   mem_val  [2][TABLE_SIZE];
    logic [31:0]   mem_hash [2][TABLE_SIZE];
    logic [7:0]    mem_dist [2][TABLE_SIZE];

    logic [KW-1:0] rd_key_reg  [2];
    logic [31:0]   rd_val_reg  [2];
    logic [31:0]   rd_hash_reg [2];
    logic [7:0]    rd_dist_reg [2];

    logic [TABLE_SIZE-1:0] cur_reg;
    logic [TABLE_SIZE-1:0] dirty_reg;
    logic [TABLE_SIZE-1:0] vld0_reg;
    logic [TABLE_SIZE-1:0] vld1_reg;

    logic [KW-1:0] c_key_reg;
    logic [31:0]   c_val_reg;
    logic [31:0]   c_hash_reg;
    logic [7:0]    n_reg;
    logic          htomb_reg;
    logic [AW-1:0] tidx_reg;
    logic [7:0]    tn_reg;
    logic [AW-1:0] idx_reg;
    logic [1:0]    req_reg;
    logic [7:0]    count_reg;
    logic [7:0]    max_reg;

    logic [1:0]    res_status_reg;
    logic [31:0]   res_value_reg;
    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [31:0]   value_out_reg;
    logic [7:0]    entry_count_reg;

    logic [15:0]   n_sq;
    logic [31:0]   probe_sum;
    logic [AW-1:0] rd_idx;
    logic          bsel;
    logic          slot_vld;
    logic [7:0]    s_dist;
    logic [KW-1:0] s_key;
    logic [31:0]   s_val;
    logic [31:0]   s_hash;

    logic          wr_data;
    logic          wr_dist;
    logic          wr_bank;
    logic [AW-1:0] wr_idx;
    logic [7:0]    wr_dval;
    logic          ins_wr;

    assign n_sq      = n_reg * n_reg;
    assign probe_sum = c_hash_reg + {16'd0, n_sq};
    assign rd_idx    = probe_sum[AW-1:0];

    assign bsel     = cur_reg[idx_reg] ^ dirty_reg[idx_reg];
    assign slot_vld = bsel ? vld1_reg[idx_reg] : vld0_reg[idx_reg];
    assign s_dist   = slot_vld ? rd_dist_reg[bsel] : DIST_EMPTY;
    assign s_key    = rd_key_reg[bsel];
    assign s_val    = rd_val_reg[bsel];
    assign s_hash   = rd_hash_reg[bsel];

    // Insert writes go to the shadow bank of the slot; remove edits the live bank.
    assign ins_wr = cmd.ins_wr_hit | cmd.ins_wr_tomb | cmd.swap;

    always_comb
    begin
        wr_idx  = idx_reg;
        wr_dval = n_reg;
        if (cmd.ins_wr_tomb || (cmd.ins_wr_hit && htomb_reg))
        begin
            wr_idx  = tidx_reg;
            wr_dval = tn_reg;
        end
        if (cmd.rem_wr)
            wr_dval = DIST_TOMB;
        wr_bank = cmd.rem_wr ? bsel : ~cur_reg[wr_idx];
        wr_data = ins_wr;
        wr_dist = ins_wr | cmd.rem_wr;
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < 2; b++)
        begin
            if (wr_data && wr_bank == 1'(b))
            begin
                mem_key[b][wr_idx]  <= c_key_reg;
                mem_val[b][wr_idx]  <= c_val_reg;
                mem_hash[b][wr_idx] <= c_hash_reg;
            end
            if (wr_dist && wr_bank == 1'(b))
                mem_dist[b][wr_idx] <= wr_dval;
            if (cmd.probe)
            begin
                rd_key_reg[b]  <= mem_key[b][rd_idx];
                rd_val_reg[b]  <= mem_val[b][rd_idx];
                rd_hash_reg[b] <= mem_hash[b][rd_idx];
                rd_dist_reg[b] <= mem_dist[b][rd_idx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            dirty_reg <= '0;
            vld0_reg  <= '0;
            vld1_reg  <= '0;
        end
        else
        begin
            if (wr_dist)
            begin
                if (wr_bank)
                    vld1_reg[wr_idx] <= 1'b1;
                else
                    vld0_reg[wr_idx] <= 1'b1;
            end
            if (cmd.commit)
            begin
                cur_reg   <= cur_reg ^ dirty_reg;
                dirty_reg <= '0;
            end
            else if (cmd.abort)
                dirty_reg <= '0;
            else if (ins_wr)
                dirty_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_key_reg  <= key[KW-1:0];
            c_val_reg  <= value;
            c_hash_reg <= key_hash;
            req_reg    <= req_type;
            n_reg      <= 8'd0;
            htomb_reg  <= 1'b0;
        end
        else if (cmd.probe)
        begin
            n_reg   <= n_reg + 8'd1;
            idx_reg <= rd_idx;
        end
        else if (cmd.tomb_rec)
        begin
            if (!htomb_reg)
            begin
                htomb_reg <= 1'b1;
                tidx_reg  <= idx_reg;
                tn_reg    <= n_reg;
            end
        end
        else if (cmd.swap)
        begin
            c_key_reg  <= s_key;
            c_val_reg  <= s_val;
            c_hash_reg <= s_hash;
            n_reg      <= s_dist;
            htomb_reg  <= 1'b0;
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= cmd.res_found ? s_val : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 8'd0;
            max_reg       <= MAX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                max_reg <= cfg_wdata;
            if (cmd.commit)
                count_reg <= count_reg + 8'd1;
            else if (cmd.dec && count_reg != 8'd0)
                count_reg <= count_reg - 8'd1;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg      <= res_status_reg;
            value_out_reg   <= res_value_reg;
            entry_count_reg <= count_reg;
        end
    end

    always_comb
    begin
        sts.req       = req_reg;
        sts.full      = (count_reg > max_reg) || (count_reg == 8'hFF);
        sts.at_bound  = n_reg >= BOUND;
        sts.have_tomb = htomb_reg;
        sts.d_empty   = s_dist == DIST_EMPTY;
        sts.d_tomb    = s_dist == DIST_TOMB;
        sts.match     = (s_hash == c_hash_reg) && (s_key == c_key_reg);
        sts.richer    = s_dist < n_reg;
        sts.out_busy  = out_valid_reg && !out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign value_out   = value_out_reg;
    assign entry_count = entry_count_reg;

endmodule

/* rtl/robin_hood_hash_table_unit.sv */
// Robin Hood hash table unit with quadratic probing and tombstones.
// A request steps through start, then probe and evaluate per slot, then commit (insert)
// and done; a walk that ends at the probe bound leaves from probe, and a full or unused
// request goes from start straight to done. One request at a time: the next beat is taken
// once the result has been handed to the output register.
// Reset (rst_n, async): all slots empty, live count zero, max_entries 96; no clearing pass.
`timescale 1ns / 1ps

module robin_hood_hash_table_unit
    import rhh_pkg::*;
#(
    parameter int TABLE_SIZE  = 128,
    parameter int PROBE_BOUND = 64,
    parameter int KEY_WIDTH   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] key,
    input  logic [31:0] key_hash,
    input  logic [31:0] value,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] value_out,
    output logic [7:0]  entry_count
);

    // Control and datapath talk only through these two structs.
    cmd_t cmd;
    sts_t sts;

    // Sequence each request: full check, probe loop, commit or drop of the
    // shadow writes, then hand the result beat to the output register.
    // Hold the finished result while the output register is still occupied.
    rhh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Slot banks, carried entry, counters and the output register.
    rhh_datapath #(
        .TABLE_SIZE  (TABLE_SIZE),
        .PROBE_BOUND (PROBE_BOUND),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .key         (key),
        .key_hash    (key_hash),
        .value       (value),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

endmodule

/* tb/robin_hood_hash_table_unit_test.sv */
// Testbench for robin_hood_hash_table_unit: directed and random request streams,
// checked against a mirror of the table kept in a small scoreboard class.
// Depends on rhh_pkg and the robin_hood_hash_table_unit RTL.
`timescale 1ns / 1ps

module robin_hood_hash_table_unit_test
    import rhh_pkg::*;
;

    localparam int          SLOTS       = 128;
    localparam int          BOUND       = 64;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          SETTLE      = 200;    // longer than the worst probe walk
    localparam int          HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [7:0]  entry_count;
    } reply_t;

    // Mirror of the table contents; predicts one reply per accepted request beat.
    class hash_table_mirror;
        logic [31:0] slot_key   [SLOTS];
        logic [31:0] slot_value [SLOTS];
        logic [31:0] slot_hash  [SLOTS];
        logic [7:0]  slot_dist  [SLOTS];
        logic [7:0]  live;
        logic [7:0]  max_entries;
        reply_t      pending_replies [$];
        int          errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_key[i] = '0;
                slot_value[i] = '0;
                slot_hash[i] = '0;
                slot_dist[i] = DIST_EMPTY;
            end
            live = '0;
            max_entries = MAX_RESET;
            errors = 0;
        endfunction

        function int probe_index(logic [31:0] h, int n);
            logic [31:0] sum;
            sum = h + 32'(n * n);
            return int'(sum % SLOTS);
        endfunction

        function bit find_entry(logic [31:0] k, logic [31:0] h, output int where);
            int idx;
            where = 0;
            for (int n = 0; n < BOUND; n++)
            begin
                idx = probe_index(h, n);
                if (slot_dist[idx] == DIST_EMPTY)
                    return 0;
                if (slot_dist[idx] != DIST_TOMB && slot_hash[idx] == h && slot_key[idx] == k)
                begin
                    where = idx;
                    return 1;
                end
            end
            return 0;
        endfunction

        // Insert works on a scratch copy; only a successful walk is committed.
        function logic [1:0] insert_entry(logic [31:0] k, logic [31:0] h, logic [31:0] v);
            logic [31:0] wk [SLOTS];
            logic [31:0] wv [SLOTS];
            logic [31:0] wh [SLOTS];
            logic [7:0]  wd [SLOTS];
            logic [31:0] ck, cv, ch;
            int          n, idx, d, tomb_idx, tomb_n;
            bit          have_tomb;
            if (live > max_entries || live == 8'd255)
                return ST_FULL;
            wk = slot_key;
            wv = slot_value;
            wh = slot_hash;
            wd = slot_dist;
            ck = k;
            cv = v;
            ch = h;
            n = 0;
            tomb_idx = 0;
            tomb_n = 0;
            have_tomb = 0;
            while (1'b1)
            begin
                if (n >= BOUND)
                begin
                    if (!have_tomb)
                        return ST_FULL;
                    idx = tomb_idx;
                    n = tomb_n;
                    break;
                end
                idx = probe_index(ch, n);
                n++;
                d = wd[idx];
                if (d == DIST_EMPTY)
                begin
                    if (have_tomb)
                    begin
                        idx = tomb_idx;
                        n = tomb_n;
                    end
                    break;
                end
                if (d == DIST_TOMB)
                begin
                    if (!have_tomb)
                    begin
                        have_tomb = 1;
                        tomb_idx = idx;
                        tomb_n = n;
                    end
                    continue;
                end
                if (wh[idx] == ch && wk[idx] == ck)
                    return ST_DUP;
                // Richer resident: swap it out and carry it on.
                if (d < n)
                begin
                    logic [31:0] tk, tv, th;
                    tk = wk[idx];
                    tv = wv[idx];
                    th = wh[idx];
                    wk[idx] = ck;
                    wv[idx] = cv;
                    wh[idx] = ch;
                    wd[idx] = 8'(n);
                    ck = tk;
                    cv = tv;
                    ch = th;
                    n = d;
                    have_tomb = 0;
                end
            end
            wk[idx] = ck;
            wv[idx] = cv;
            wh[idx] = ch;
            wd[idx] = 8'(n);
            slot_key = wk;
            slot_value = wv;
            slot_hash = wh;
            slot_dist = wd;
            live = live + 8'd1;
            return ST_OK;
        endfunction

        function void note_request(logic [1:0] req, logic [31:0] k, logic [31:0] h,
                                   logic [31:0] v);
            reply_t r;
            int     where;
            r.status = ST_MISS;
            r.value_out = '0;
            if (req == REQ_INSERT)
                r.status = insert_entry(k, h, v);
            else if ((req == REQ_LOOKUP || req == REQ_REMOVE) && find_entry(k, h, where))
            begin
                r.status = ST_OK;
                r.value_out = slot_value[where];
                if (req == REQ_REMOVE)
                begin
                    slot_dist[where] = DIST_TOMB;
                    if (live != 0)
                        live = live - 8'd1;
                end
            end
            r.entry_count = live;
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [1:0] st, logic [31:0] vo, logic [7:0] cnt);
            reply_t e;
            if (pending_replies.size() == 0)
            begin
                $error("reply beat with nothing pending: status %0d", st);
                errors++;
                return;
            end
            e = pending_replies.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (vo !== e.value_out)
            begin
                $error("value_out: expected %h, got %h", e.value_out, vo);
                errors++;
            end
            if (cnt !== e.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", e.entry_count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic [31:0] value;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [7:0]  entry_count;

    hash_table_mirror mirror;
    bit               calm;      // no random idling on either side
    bit               hold_req;  // ask the receiver for one long hold-off
    int               cycles = 0;

    // Key pool for the current phase; hashes can cluster so that probe walks collide.
    logic [31:0] pool_key  [64];
    logic [31:0] pool_hash [64];
    int          pool_size;

    robin_hood_hash_table_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .key         (key),
        .key_hash    (key_hash),
        .value       (value),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("robin_hood_hash_table_unit_test: errors");
            $finish;
        end
    end

    // Monitor both channels on the edge where each beat moves.
    always @(posedge clk)
    begin
        if (rst_n && mirror != null)
        begin
            if (out_valid && out_ready)
                mirror.check_reply(status, value_out, entry_count);
            if (in_valid && in_ready)
                mirror.note_request(req_type, key, key_hash, value);
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 6);
        end
    end

    // Offer one request beat and hold it until accepted.
    task automatic send_request(logic [1:0] req, logic [31:0] k, logic [31:0] h,
                                logic [31:0] v);
        if (!calm && $urandom_range(0, 99) < 6)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        key <= k;
        key_hash <= h;
        value <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid, wait for every reply, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (mirror.pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_max_entries(logic [7:0] limit);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
        mirror.max_entries = limit;
    endtask

    // cluster 0 means fully random hashes; otherwise homes fall in the lowest cluster slots.
    task automatic make_pool(int size, int cluster);
        pool_size = size;
        for (int i = 0; i < size; i++)
        begin
            pool_key[i] = $urandom;
            if (cluster == 0)
                pool_hash[i] = $urandom;
            else
                pool_hash[i] = ($urandom & 32'hFFFF_FF80) | 32'($urandom_range(0, cluster - 1));
            // Same key under another hash must not count as a duplicate.
            if (i > 0 && $urandom_range(0, 9) == 0)
                pool_key[i] = pool_key[i - 1];
        end
    endtask

    task automatic run_phase(int count, int ins_pct, int look_pct, int rem_pct);
        int r, p;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            p = $urandom_range(0, pool_size - 1);
            if (r < ins_pct)
                send_request(REQ_INSERT, pool_key[p], pool_hash[p], $urandom);
            else if (r < ins_pct + look_pct)
                send_request(REQ_LOOKUP, pool_key[p], pool_hash[p], $urandom);
            else if (r < ins_pct + look_pct + rem_pct)
                send_request(REQ_REMOVE, pool_key[p], pool_hash[p], $urandom);
            else
                send_request(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_INSERT;
        key = '0;
        key_hash = '0;
        value = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        out_ready = 1'b0;
        calm = 0;
        hold_req = 0;
        mirror = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every request type, tombstone reuse, duplicates.
        send_request(REQ_LOOKUP, 32'h0, 32'h0, 32'h0);                   // empty table
        send_request(REQ_INSERT, 32'h0, 32'h0, 32'h0);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h0, 32'h0, 32'h1234_5678);           // duplicate
        send_request(REQ_INSERT, 32'h0, 32'h0000_0080, 32'hA5A5_A5A5);   // same key, new hash
        send_request(REQ_INSERT, 32'h1, 32'h0, 32'h5A5A_5A5A);           // collides at home 0
        send_request(REQ_INSERT, 32'h2, 32'h0, 32'h0F0F_0F0F);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_request(REQ_LOOKUP, 32'h2, 32'h0, 32'h0);
        send_request(REQ_LOOKUP, 32'h3, 32'h0, 32'h0);                   // miss past cluster
        send_request(REQ_REMOVE, 32'h1, 32'h0, 32'hFFFF_FFFF);
        send_request(REQ_LOOKUP, 32'h2, 32'h0, 32'h0);                   // walks past tombstone
        send_request(REQ_REMOVE, 32'h1, 32'h0, 32'h0);                   // already gone
        send_request(REQ_INSERT, 32'h7, 32'h0, 32'h7777_7777);           // reuses tombstone
        send_request(REQ_INSERT, 32'h2, 32'h0, 32'h0);                   // duplicate past reused slot
        send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        set_max_entries(8'd1);                                           // load limit
        send_request(REQ_INSERT, 32'h9, 32'h9, 32'h9);
        send_request(REQ_REMOVE, 32'h7, 32'h0, 32'h0);
        send_request(REQ_REMOVE, 32'h2, 32'h0, 32'h0);
        send_request(REQ_INSERT, 32'h9, 32'h9, 32'h9);
        send_request(REQ_INSERT, 32'hA, 32'hA, 32'hA);                   // live 2 above 1, refused
        send_request(REQ_INSERT, 32'hB, 32'hB, 32'hB);                   // still refused

        // Mixed traffic at limit 128, with the long receiver hold-off midway.
        set_max_entries(8'd128);
        make_pool(48, 16);
        run_phase(100, 45, 25, 25);
        hold_req = 1;
        run_phase(100, 45, 25, 25);

        // Stretch with no idling on either side, spread-out hashes.
        drain();
        calm = 1;
        make_pool(64, 0);
        run_phase(180, 50, 25, 20);
        calm = 0;

        // Fill hard: tight clusters exhaust the probe bound.
        set_max_entries(8'd128);
        make_pool(64, 4);
        run_phase(200, 80, 10, 8);

        // Limit 1, the smallest in this bench, lots of churn around it.
        set_max_entries(8'd1);
        make_pool(16, 8);
        run_phase(150, 40, 25, 30);

        // Mid limits including the reset value.
        set_max_entries(MAX_RESET);
        make_pool(64, 32);
        run_phase(200, 50, 25, 20);
        set_max_entries(8'($urandom_range(2, 127)));
        make_pool(40, 8);
        run_phase(200, 45, 25, 25);

        drain();
        if (mirror.errors == 0)
            $display("robin_hood_hash_table_unit_test: clean");
        else
            $display("robin_hood_hash_table_unit_test: errors");
        $finish;
    end

endmodule
